// ===== src/rtu_pkg.sv =====
// ============================================================================
// rtu_pkg
// Shared types and constants for the RV32 trap entry unit: item layouts,
// configuration register indexes, interrupt codes and mstatus bit positions.
// ============================================================================
package rtu_pkg;

    localparam int XLEN       = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int CAUSE_W    = 6;
    localparam int IRQ_CODE_W = 4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MTVEC   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STVEC   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MEDELEG = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIDELEG = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MIE     = 3'd4;

    // Privilege levels
    localparam logic [1:0] PRIV_U = 2'd0;
    localparam logic [1:0] PRIV_S = 2'd1;
    localparam logic [1:0] PRIV_M = 2'd3;

    // Trap vector mode field
    localparam logic [1:0] VEC_MODE_VECTORED = 2'b01;

    // Interrupt codes
    localparam logic [IRQ_CODE_W-1:0] IRQ_SSI = 4'd1;
    localparam logic [IRQ_CODE_W-1:0] IRQ_MSI = 4'd3;
    localparam logic [IRQ_CODE_W-1:0] IRQ_STI = 4'd5;
    localparam logic [IRQ_CODE_W-1:0] IRQ_MTI = 4'd7;
    localparam logic [IRQ_CODE_W-1:0] IRQ_SEI = 4'd9;
    localparam logic [IRQ_CODE_W-1:0] IRQ_MEI = 4'd11;

    // Interrupt class masks and the cause flag
    localparam logic [XLEN-1:0] M_LIST_MASK = 32'h0000_0AAA;
    localparam logic [XLEN-1:0] S_LIST_MASK = 32'h0000_0222;
    localparam logic [XLEN-1:0] INTR_FLAG   = 32'h8000_0000;

    // mstatus bit positions
    localparam int ST_SIE    = 1;
    localparam int ST_MIE    = 3;
    localparam int ST_SPIE   = 5;
    localparam int ST_MPIE   = 7;
    localparam int ST_SPP    = 8;
    localparam int ST_MPP_LO = 11;
    localparam int ST_MPP_HI = 12;

    typedef struct packed {
        logic [1:0]         current_priv;
        logic [XLEN-1:0]    status_word;
        logic [XLEN-1:0]    next_pc;
        logic               exc_valid;
        logic [CAUSE_W-1:0] exc_cause;
        logic [XLEN-1:0]    exc_value;
        logic [XLEN-1:0]    soft_pending;
        logic               msip_line;
        logic               mtip_line;
        logic               meip_line;
    } req_item_t;

    typedef struct packed {
        logic            trap_taken;
        logic            to_supervisor;
        logic [XLEN-1:0] handler_pc;
        logic [XLEN-1:0] trap_cause;
        logic [XLEN-1:0] trap_value;
        logic [XLEN-1:0] saved_pc;
        logic [1:0]      new_priv;
        logic [XLEN-1:0] new_status;
        logic [XLEN-1:0] new_pending;
    } rsp_item_t;

    typedef struct packed {
        logic [XLEN-1:0]       m_trap_vector;
        logic [XLEN-1:0]       s_trap_vector;
        logic [CFG_DATA_W-1:0] exception_delegation;
        logic [XLEN-1:0]       interrupt_delegation;
        logic [XLEN-1:0]       interrupt_enable;
    } cfg_regs_t;

endpackage

// ===== src/rtu_intf.sv =====
// ============================================================================
// rtu_intf
// Valid/ready channels of the trap entry unit: request items, result items
// and the configuration write channel.
// ============================================================================

// Request channel: one beat per retired instruction
interface rtu_req_if
    import rtu_pkg::*;
();
    logic      valid;
    logic      ready;
    req_item_t item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

// Result channel: one beat per request
interface rtu_rsp_if
    import rtu_pkg::*;
();
    logic      valid;
    logic      ready;
    rsp_item_t item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

// Configuration write channel
interface rtu_cfg_if
    import rtu_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== src/rtu_decide.sv =====
// ============================================================================
// rtu_decide
// Trap decision for one request: merges the interrupt lines into mip,
// picks an exception or the highest priority enabled interrupt, and builds
// the handler pc, cause, tval, epc, new privilege and new mstatus.
// ============================================================================
module rtu_decide
    import rtu_pkg::*;
(
    input  req_item_t item,
    input  cfg_regs_t regs,
    output rsp_item_t result
);

    logic [XLEN-1:0]       mip;
    logic [XLEN-1:0]       m_irq;
    logic [XLEN-1:0]       s_irq;
    logic                  m_ok;
    logic                  s_ok;
    logic                  exc_deleg;
    logic [IRQ_CODE_W-1:0] m_code;
    logic [IRQ_CODE_W-1:0] s_code;

    // Merge the line bits into the pending word and mask each class
    always_comb
    begin
        mip = item.soft_pending;
        mip[IRQ_MSI] = item.msip_line;
        mip[IRQ_MTI] = item.mtip_line;
        mip[IRQ_MEI] = item.meip_line;
        m_irq = mip & regs.interrupt_enable & ~regs.interrupt_delegation & M_LIST_MASK;
        s_irq = mip & regs.interrupt_enable & regs.interrupt_delegation & S_LIST_MASK;
        m_ok  = (m_irq != '0) &&
                ((item.current_priv != PRIV_M) || item.status_word[ST_MIE]);
        s_ok  = (s_irq != '0) &&
                (((item.current_priv == PRIV_S) && item.status_word[ST_SIE]) ||
                 (item.current_priv == PRIV_U));
        exc_deleg = (item.current_priv != PRIV_M) &&
                    regs.exception_delegation[item.exc_cause];
    end

    // Fixed priority pick: M class 11,3,7,9,1,5
    always_comb
    begin
        if (m_irq[IRQ_MEI])
            m_code = IRQ_MEI;
        else if (m_irq[IRQ_MSI])
            m_code = IRQ_MSI;
        else if (m_irq[IRQ_MTI])
            m_code = IRQ_MTI;
        else if (m_irq[IRQ_SEI])
            m_code = IRQ_SEI;
        else if (m_irq[IRQ_SSI])
            m_code = IRQ_SSI;
        else
            m_code = IRQ_STI;
    end

    // Fixed priority pick: S class 9,1,5
    always_comb
    begin
        if (s_irq[IRQ_SEI])
            s_code = IRQ_SEI;
        else if (s_irq[IRQ_SSI])
            s_code = IRQ_SSI;
        else
            s_code = IRQ_STI;
    end

    // Build the result
    always_comb
    begin
        logic                  take;
        logic                  to_s;
        logic                  intr;
        logic [IRQ_CODE_W-1:0] code;
        logic [XLEN-1:0]       vec;
        logic [XLEN-1:0]       base;
        logic [XLEN-1:0]       st;

        take = 1'b0;
        to_s = 1'b0;
        intr = 1'b0;
        code = m_code;
        if (item.exc_valid)
        begin
            take = 1'b1;
            to_s = exc_deleg;
        end
        else if (m_ok)
        begin
            take = 1'b1;
            intr = 1'b1;
        end
        else if (s_ok)
        begin
            take = 1'b1;
            to_s = 1'b1;
            intr = 1'b1;
            code = s_code;
        end

        // Handler address, vectored only for interrupts in mode 1
        vec  = to_s ? regs.s_trap_vector : regs.m_trap_vector;
        base = {vec[XLEN-1:2], 2'b00};
        if (intr && (vec[1:0] == VEC_MODE_VECTORED))
            base = base + {{(XLEN-IRQ_CODE_W-2){1'b0}}, code, 2'b00};

        // Stack the interrupt enable and previous privilege
        st = item.status_word;
        if (to_s)
        begin
            st[ST_SPIE] = item.status_word[ST_SIE];
            st[ST_SIE]  = 1'b0;
            st[ST_SPP]  = item.current_priv[0];
        end
        else
        begin
            st[ST_MPIE] = item.status_word[ST_MIE];
            st[ST_MIE]  = 1'b0;
            st[ST_MPP_HI:ST_MPP_LO] = item.current_priv;
        end

        result.new_pending = mip;
        if (take)
        begin
            result.trap_taken    = 1'b1;
            result.to_supervisor = to_s;
            result.handler_pc    = base;
            result.trap_cause    = intr ? (INTR_FLAG | {{(XLEN-IRQ_CODE_W){1'b0}}, code})
                                        : {{(XLEN-CAUSE_W){1'b0}}, item.exc_cause};
            result.trap_value    = intr ? '0 : item.exc_value;
            result.saved_pc      = item.next_pc;
            result.new_priv      = to_s ? PRIV_S : PRIV_M;
            result.new_status    = st;
        end
        else
        begin
            result.trap_taken    = 1'b0;
            result.to_supervisor = 1'b0;
            result.handler_pc    = item.next_pc;
            result.trap_cause    = '0;
            result.trap_value    = '0;
            result.saved_pc      = '0;
            result.new_priv      = item.current_priv;
            result.new_status    = item.status_word;
        end
    end

endmodule

// ===== src/riscv_trap_entry_unit_top.sv =====
// ============================================================================
// riscv_trap_entry_unit_top
// RV32 trap entry for one hart. Each request beat carries the state after a
// retired instruction; each result beat tells whether a trap is entered and
// gives the handler pc, cause, tval, epc, new privilege, new mstatus and the
// merged mip. The unit takes one request per cycle unless a stalled result
// backs up into a full request register. Each request passes through the
// request register, the trap decision and the result register. A stalled
// result holds the result register and a full request register; a new request
// is still taken while the request register is empty. Configuration writes are
// always accepted and apply to requests evaluated from the next cycle on.
// ============================================================================
module riscv_trap_entry_unit_top
    import rtu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    rtu_req_if.sink     trap_req,
    rtu_rsp_if.source   trap_rsp,
    rtu_cfg_if.sink     cfg
);

    logic      req_valid_reg;
    req_item_t req_item_reg;
    logic      rsp_valid_reg;
    rsp_item_t rsp_item_reg;
    cfg_regs_t cfg_reg;
    rsp_item_t decide_result;
    logic      rsp_free;
    logic      req_free;

    // Stage handshakes
    assign rsp_free       = !rsp_valid_reg || trap_rsp.ready;
    assign req_free       = !req_valid_reg || rsp_free;
    assign trap_req.ready = req_free;
    assign cfg.ready      = 1'b1;
    assign trap_rsp.valid = rsp_valid_reg;
    assign trap_rsp.item  = rsp_item_reg;

    // Hold configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_MTVEC:   cfg_reg.m_trap_vector        <= cfg.data[XLEN-1:0];
                CFG_STVEC:   cfg_reg.s_trap_vector        <= cfg.data[XLEN-1:0];
                CFG_MEDELEG: cfg_reg.exception_delegation <= cfg.data;
                CFG_MIDELEG: cfg_reg.interrupt_delegation <= cfg.data[XLEN-1:0];
                CFG_MIE:     cfg_reg.interrupt_enable     <= cfg.data[XLEN-1:0];
                default:     ;
            endcase
        end
    end

    // Advance the request register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            req_valid_reg <= 1'b0;
        else if (req_free)
            req_valid_reg <= trap_req.valid;
    end

    always_ff @(posedge clk)
    begin
        if (req_free && trap_req.valid)
            req_item_reg <= trap_req.item;
    end

    rtu_decide u_decide (
        .item   (req_item_reg),
        .regs   (cfg_reg),
        .result (decide_result)
    );

    // Advance the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (rsp_free)
            rsp_valid_reg <= req_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (rsp_free && req_valid_reg)
            rsp_item_reg <= decide_result;
    end

`ifndef SYNTH
    // An accepted request beat occupies the request register next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (trap_req.valid && trap_req.ready) |=> req_valid_reg)
        else $error("accepted request beat lost");

    // M-mode trap lands in machine level
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_item_reg.trap_taken && !rsp_item_reg.to_supervisor)
            |-> (rsp_item_reg.new_priv == PRIV_M))
        else $error("M-mode trap with wrong privilege");

    // S-mode trap lands in supervisor level with SIE cleared
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_item_reg.trap_taken && rsp_item_reg.to_supervisor)
            |-> (rsp_item_reg.new_priv == PRIV_S && !rsp_item_reg.new_status[ST_SIE]))
        else $error("S-mode trap with wrong privilege or SIE");

    // No trap leaves cause, tval and epc at zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && !rsp_item_reg.trap_taken)
            |-> (rsp_item_reg.trap_cause == '0 && rsp_item_reg.trap_value == '0 &&
                 rsp_item_reg.saved_pc == '0))
        else $error("trap fields set without a trap");
`endif

endmodule

// ===== dv/tb_riscv_trap_entry_unit_top.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb_riscv_trap_entry_unit_top
// Self-checking bench for the RV32 trap entry unit. A scoreboard class predicts
// each result beat from the request beat and its own copy of the trap CSRs.
// Directed beats cover each trap path, then random phases run under several
// CSR settings with bursty requests and a stalling result sink.
// ============================================================================
module tb_riscv_trap_entry_unit_top;
    import rtu_pkg::*;

    localparam int  NUM_PHASES     = 10;
    localparam int  BEATS_PER_PHASE = 110;
    localparam int  DRAIN_CYCLES   = 6;
    localparam int  MAX_MISMATCH_LINES = 100;
    localparam time RUN_LIMIT      = 4ms;

    localparam logic [XLEN-1:0] MIE_ON = 32'h1 << ST_MIE;
    localparam logic [XLEN-1:0] SIE_ON = 32'h1 << ST_SIE;

    // Interrupt line bundles, ordered {meip, mtip, msip}
    localparam logic [2:0] LN_NONE = 3'b000;
    localparam logic [2:0] LN_MSIP = 3'b001;
    localparam logic [2:0] LN_MTIP = 3'b010;
    localparam logic [2:0] LN_MEIP = 3'b100;
    localparam logic [2:0] LN_ALL  = 3'b111;

    localparam logic [1:0] PRIV_RSVD = 2'd2;

    typedef enum int {STALL_NONE, STALL_RANDOM, STALL_PATTERN, STALL_LONG} stall_mode_t;

    // ------------------------------------------------------------------------
    // Scoreboard: trap-entry predictor plus queue of awaited result beats
    // ------------------------------------------------------------------------
    class trap_entry_checker;
        cfg_regs_t   csr;
        rsp_item_t   awaited_traps [$];
        int unsigned errors;

        function new();
            csr    = '0;
            errors = 0;
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] index,
                                     logic [CFG_DATA_W-1:0] data);
            case (index)
                CFG_MTVEC:   csr.m_trap_vector        = data[XLEN-1:0];
                CFG_STVEC:   csr.s_trap_vector        = data[XLEN-1:0];
                CFG_MEDELEG: csr.exception_delegation = data;
                CFG_MIDELEG: csr.interrupt_delegation = data[XLEN-1:0];
                CFG_MIE:     csr.interrupt_enable     = data[XLEN-1:0];
                default: ;
            endcase
        endfunction

        // Fill in the trap fields and the mstatus stacking for one trap
        function rsp_item_t take_trap(rsp_item_t res, req_item_t r, bit to_s,
                                      logic [XLEN-1:0] cause, logic [XLEN-1:0] tval);
            logic [XLEN-1:0] vec;
            logic [XLEN-1:0] st;
            st = r.status_word;
            if (to_s)
            begin
                st[ST_SPIE] = r.status_word[ST_SIE];
                st[ST_SIE]  = 1'b0;
                st[ST_SPP]  = r.current_priv[0];
                vec = csr.s_trap_vector;
                res.new_priv = PRIV_S;
            end
            else
            begin
                st[ST_MPIE] = r.status_word[ST_MIE];
                st[ST_MIE]  = 1'b0;
                st[ST_MPP_HI:ST_MPP_LO] = r.current_priv;
                vec = csr.m_trap_vector;
                res.new_priv = PRIV_M;
            end
            res.handler_pc = {vec[XLEN-1:2], 2'b00};
            if (vec[1:0] == VEC_MODE_VECTORED && cause[XLEN-1])
                res.handler_pc = res.handler_pc + {cause[XLEN-3:0], 2'b00};
            res.trap_taken    = 1'b1;
            res.to_supervisor = to_s;
            res.trap_cause    = cause;
            res.trap_value    = tval;
            res.saved_pc      = r.next_pc;
            res.new_status    = st;
            return res;
        endfunction

        function rsp_item_t predict_trap_entry(req_item_t r);
            rsp_item_t res;
            logic [XLEN-1:0] mip;
            logic [XLEN-1:0] m_cand;
            logic [XLEN-1:0] s_cand;
            logic [IRQ_CODE_W-1:0] m_order [6];
            logic [IRQ_CODE_W-1:0] s_order [3];
            bit done;
            m_order = '{IRQ_MEI, IRQ_MSI, IRQ_MTI, IRQ_SEI, IRQ_SSI, IRQ_STI};
            s_order = '{IRQ_SEI, IRQ_SSI, IRQ_STI};
            done = 1'b0;

            // Merge the three line bits over the software-held mip
            mip = r.soft_pending;
            mip[IRQ_MSI] = r.msip_line;
            mip[IRQ_MTI] = r.mtip_line;
            mip[IRQ_MEI] = r.meip_line;
            m_cand = mip & csr.interrupt_enable & ~csr.interrupt_delegation & M_LIST_MASK;
            s_cand = mip & csr.interrupt_enable & csr.interrupt_delegation & S_LIST_MASK;

            res = '0;
            res.handler_pc  = r.next_pc;
            res.new_priv    = r.current_priv;
            res.new_status  = r.status_word;
            res.new_pending = mip;

            if (r.exc_valid)
            begin
                res = take_trap(res, r,
                                r.current_priv != PRIV_M
                                    && csr.exception_delegation[r.exc_cause],
                                XLEN'(r.exc_cause), r.exc_value);
            end
            else if (m_cand != '0 && (r.current_priv != PRIV_M || r.status_word[ST_MIE]))
            begin
                for (int k = 0; k < 6; k++)
                begin
                    if (!done && m_cand[m_order[k]])
                    begin
                        res  = take_trap(res, r, 1'b0, INTR_FLAG | XLEN'(m_order[k]), '0);
                        done = 1'b1;
                    end
                end
            end
            else if (s_cand != '0 && ((r.current_priv == PRIV_S && r.status_word[ST_SIE])
                                      || r.current_priv == PRIV_U))
            begin
                for (int k = 0; k < 3; k++)
                begin
                    if (!done && s_cand[s_order[k]])
                    begin
                        res  = take_trap(res, r, 1'b1, INTR_FLAG | XLEN'(s_order[k]), '0);
                        done = 1'b1;
                    end
                end
            end
            return res;
        endfunction

        function void note_request(req_item_t r);
            awaited_traps.push_back(predict_trap_entry(r));
        endfunction

        function int pending();
            return awaited_traps.size();
        endfunction

        task report(string msg);
            if (errors < MAX_MISMATCH_LINES)
                $display("[%0t] MISMATCH %s", $time, msg);
            errors++;
        endtask

        task check_field(string name, logic [XLEN-1:0] got, logic [XLEN-1:0] want);
            if (got !== want)
                report($sformatf("%s: got %h, expected %h", name, got, want));
        endtask

        task check_result(rsp_item_t got);
            rsp_item_t want;
            if (awaited_traps.size() == 0)
            begin
                report("result beat with no request outstanding");
                return;
            end
            want = awaited_traps.pop_front();
            check_field("trap_taken",    XLEN'(got.trap_taken),    XLEN'(want.trap_taken));
            check_field("to_supervisor", XLEN'(got.to_supervisor), XLEN'(want.to_supervisor));
            check_field("handler_pc",    got.handler_pc,           want.handler_pc);
            check_field("trap_cause",    got.trap_cause,           want.trap_cause);
            check_field("trap_value",    got.trap_value,           want.trap_value);
            check_field("saved_pc",      got.saved_pc,             want.saved_pc);
            check_field("new_priv",      XLEN'(got.new_priv),      XLEN'(want.new_priv));
            check_field("new_status",    got.new_status,           want.new_status);
            check_field("new_pending",   got.new_pending,          want.new_pending);
        endtask
    endclass

    logic clk;
    logic rst_n;

    rtu_req_if req_ch ();
    rtu_rsp_if rsp_ch ();
    rtu_cfg_if cfg_ch ();

    trap_entry_checker sb;

    stall_mode_t rsp_stall_mode;
    int          stall_phase;
    int          stall_left;
    bit          sender_gaps;
    int          burst_left;

    riscv_trap_entry_unit_top DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .trap_req (req_ch),
        .trap_rsp (rsp_ch),
        .cfg      (cfg_ch)
    );

    // Clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Monitor accepted beats on all three channels
    always @(posedge clk)
    begin
        if (rst_n && cfg_ch.valid && cfg_ch.ready)
            sb.write_register(cfg_ch.index, cfg_ch.data);
        if (rst_n && req_ch.valid && req_ch.ready)
            sb.note_request(req_ch.item);
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
            sb.check_result(rsp_ch.item);
    end

    // Result sink backpressure
    always @(negedge clk)
    begin
        case (rsp_stall_mode)
            STALL_NONE:
                rsp_ch.ready <= 1'b1;
            STALL_RANDOM:
                rsp_ch.ready <= ($urandom_range(0, 3) != 0);
            STALL_PATTERN:
            begin
                stall_phase = (stall_phase + 1) % 7;
                rsp_ch.ready <= (stall_phase < 4);
            end
            default:
            begin
                if (stall_left > 0)
                begin
                    stall_left--;
                    rsp_ch.ready <= 1'b0;
                end
                else if ($urandom_range(0, 9) == 0)
                begin
                    stall_left = $urandom_range(2, 20);
                    rsp_ch.ready <= 1'b0;
                end
                else
                    rsp_ch.ready <= 1'b1;
            end
        endcase
    end

    function automatic logic [XLEN-1:0] irq_bit(logic [IRQ_CODE_W-1:0] code);
        return XLEN'(1) << code;
    endfunction

    function automatic req_item_t make_request(logic [1:0] priv, logic [XLEN-1:0] status,
                                               logic exc, logic [CAUSE_W-1:0] cause,
                                               logic [XLEN-1:0] sw_bits, logic [2:0] lines);
        req_item_t r;
        r.current_priv = priv;
        r.status_word  = status;
        r.next_pc      = $urandom;
        r.exc_valid    = exc;
        r.exc_cause    = cause;
        r.exc_value    = $urandom;
        r.soft_pending = sw_bits;
        r.msip_line    = lines[0];
        r.mtip_line    = lines[1];
        r.meip_line    = lines[2];
        return r;
    endfunction

    function automatic req_item_t random_request();
        logic [1:0]         priv;
        logic [XLEN-1:0]    sw_bits;
        logic [CAUSE_W-1:0] cause;
        case ($urandom_range(0, 9))
            0, 1, 2: priv = PRIV_U;
            3, 4, 5: priv = PRIV_S;
            6, 7, 8: priv = PRIV_M;
            default: priv = PRIV_RSVD;
        endcase
        case ($urandom_range(0, 3))
            0:       sw_bits = $urandom;
            1:       sw_bits = '0;
            default: sw_bits = $urandom & $urandom & M_LIST_MASK;
        endcase
        cause = $urandom_range(0, 1) ? CAUSE_W'($urandom_range(0, 15)) : CAUSE_W'($urandom);
        return make_request(priv, $urandom, $urandom_range(0, 3) == 0, cause, sw_bits,
                            3'($urandom & $urandom));
    endfunction

    function automatic cfg_regs_t random_config(int phase);
        cfg_regs_t c;
        case (phase)
            0: c = '0;
            1: c = '1;
            2:
            begin
                c.m_trap_vector        = {$urandom_range(0, 255) << 2} | VEC_MODE_VECTORED;
                c.s_trap_vector        = $urandom | VEC_MODE_VECTORED;
                c.exception_delegation = {$urandom, $urandom};
                c.interrupt_delegation = S_LIST_MASK;
                c.interrupt_enable     = '1;
            end
            default:
            begin
                c.m_trap_vector = $urandom;
                c.s_trap_vector = $urandom;
                if ($urandom_range(0, 1))
                    c.m_trap_vector[1:0] = VEC_MODE_VECTORED;
                if ($urandom_range(0, 1))
                    c.s_trap_vector[1:0] = VEC_MODE_VECTORED;
                c.exception_delegation = {$urandom, $urandom};
                c.interrupt_delegation = $urandom;
                c.interrupt_enable     = $urandom | ($urandom & M_LIST_MASK);
            end
        endcase
        return c;
    endfunction

    // Write all five CSRs, one beat each; called at a falling edge
    task automatic load_config(cfg_regs_t c);
        logic [CFG_IDX_W-1:0]  idx  [5];
        logic [CFG_DATA_W-1:0] vals [5];
        idx  = '{CFG_MTVEC, CFG_STVEC, CFG_MEDELEG, CFG_MIDELEG, CFG_MIE};
        vals = '{CFG_DATA_W'(c.m_trap_vector), CFG_DATA_W'(c.s_trap_vector),
                 c.exception_delegation, CFG_DATA_W'(c.interrupt_delegation),
                 CFG_DATA_W'(c.interrupt_enable)};
        for (int i = 0; i < 5; i++)
        begin
            cfg_ch.index <= idx[i];
            cfg_ch.data  <= vals[i];
            cfg_ch.valid <= 1'b1;
            @(posedge clk);
            while (!cfg_ch.ready)
                @(posedge clk);
            @(negedge clk);
        end
        cfg_ch.valid <= 1'b0;
    endtask

    // Drive one request beat in bursts; called and returns at a falling edge
    task automatic send_request(req_item_t r);
        int gap;
        if (burst_left == 0)
        begin
            gap = sender_gaps ? $urandom_range(0, 7) : 0;
            burst_left = $urandom_range(1, 16);
            if (gap != 0)
            begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        req_ch.item  <= r;
        req_ch.valid <= 1'b1;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        @(negedge clk);
        burst_left--;
    endtask

    // Drop valid and hold until every awaited result beat is back
    task automatic drain();
        req_ch.valid <= 1'b0;
        burst_left = 0;
        while (sb.pending() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Run limit
    initial
    begin
        #(RUN_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        cfg_regs_t c;
        sb = new();
        clk = 1'b0;
        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.item  = '0;
        rsp_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data  = '0;
        rsp_stall_mode = STALL_NONE;
        stall_phase = 0;
        stall_left  = 0;
        sender_gaps = 1'b0;
        burst_left  = 0;

        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed, first setting: vectored M base at the top of memory,
        // S vector in mode 2, only STI delegated, every enable set
        c.m_trap_vector        = 32'hFFFF_FFFD;
        c.s_trap_vector        = 32'h0000_1002;
        c.exception_delegation = 64'h8000_0000_0000_0100;
        c.interrupt_delegation = irq_bit(IRQ_STI);
        c.interrupt_enable     = '1;
        load_config(c);
        rsp_stall_mode = STALL_RANDOM;

        // Nothing pending: no trap
        send_request(make_request(PRIV_M, '1, 1'b0, 6'd0, '0, LN_NONE));
        // Delegated exception from U, not delegated from M
        send_request(make_request(PRIV_U, $urandom, 1'b1, 6'd8, '0, LN_NONE));
        send_request(make_request(PRIV_M, $urandom, 1'b1, 6'd8, '0, LN_NONE));
        // Cause above 31 delegated through the upper half of medeleg
        send_request(make_request(PRIV_S, $urandom, 1'b1, 6'd63, '0, LN_NONE));
        // Reserved level: undelegated cause to M, delegated cause to S with SPP clear
        send_request(make_request(PRIV_RSVD, $urandom, 1'b1, 6'd2, '0, LN_NONE));
        send_request(make_request(PRIV_RSVD, '1, 1'b1, 6'd8, '0, LN_NONE));
        // Exception wins over everything pending
        send_request(make_request(PRIV_M, '1, 1'b1, 6'd0, '1, LN_ALL));
        // Everything pending at M with MIE: external first, vectored wrap
        send_request(make_request(PRIV_M, MIE_ON, 1'b0, '1, '1, LN_ALL));
        // Software copies of the line bits are ignored
        send_request(make_request(PRIV_U, '1, 1'b0, '1,
                                  irq_bit(IRQ_MSI) | irq_bit(IRQ_MTI) | irq_bit(IRQ_MEI),
                                  LN_NONE));
        // M interrupts at M gated by MIE
        send_request(make_request(PRIV_M, ~MIE_ON, 1'b0, '0, '0, LN_MSIP));
        send_request(make_request(PRIV_M, MIE_ON, 1'b0, '0, '0, LN_MSIP));
        // Priority order among M interrupts
        send_request(make_request(PRIV_M, '1, 1'b0, '0,
                                  irq_bit(IRQ_SEI) | irq_bit(IRQ_SSI), LN_MTIP));
        send_request(make_request(PRIV_S, '0, 1'b0, '0,
                                  irq_bit(IRQ_SEI) | irq_bit(IRQ_SSI), LN_NONE));
        send_request(make_request(PRIV_U, '0, 1'b0, '0,
                                  irq_bit(IRQ_SSI) | irq_bit(IRQ_STI), LN_NONE));
        // Delegated STI: taken from U, gated by SIE at S, never at M or reserved
        send_request(make_request(PRIV_U, '0, 1'b0, '0, irq_bit(IRQ_STI), LN_NONE));
        send_request(make_request(PRIV_S, ~SIE_ON, 1'b0, '0, irq_bit(IRQ_STI), LN_NONE));
        send_request(make_request(PRIV_S, SIE_ON, 1'b0, '0, irq_bit(IRQ_STI), LN_NONE));
        send_request(make_request(PRIV_M, '1, 1'b0, '0, irq_bit(IRQ_STI), LN_NONE));
        send_request(make_request(PRIV_RSVD, '1, 1'b0, '0, irq_bit(IRQ_STI), LN_NONE));
        // Unlisted pending bits only: no trap
        send_request(make_request(PRIV_U, '1, 1'b0, '0, ~(M_LIST_MASK), LN_NONE));
        // Reserved level counts as below M even with MIE clear
        send_request(make_request(PRIV_RSVD, '0, 1'b0, '0, '0, LN_MEIP));
        drain();

        // Directed, second setting: everything delegated, vectored S base
        c.m_trap_vector        = '0;
        c.s_trap_vector        = 32'hFFFF_FFFD;
        c.exception_delegation = '1;
        c.interrupt_delegation = '1;
        c.interrupt_enable     = '1;
        load_config(c);
        rsp_stall_mode = STALL_LONG;
        sender_gaps = 1'b1;

        send_request(make_request(PRIV_U, '0, 1'b0, '0, S_LIST_MASK, LN_NONE));
        send_request(make_request(PRIV_S, SIE_ON, 1'b0, '0,
                                  irq_bit(IRQ_SSI) | irq_bit(IRQ_STI), LN_NONE));
        // Exceptions ignore vectored mode
        send_request(make_request(PRIV_U, '1, 1'b1, 6'd5, '0, LN_NONE));
        // Line bits delegated away from M but outside the S list: no trap
        send_request(make_request(PRIV_U, '1, 1'b0, '0, '0, LN_ALL));
        drain();

        // Random phases, each under its own CSR setting and idling mix
        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            load_config(random_config(phase));
            rsp_stall_mode = stall_mode_t'(phase % 4);
            sender_gaps    = (phase % 3 != 0);
            for (int n = 0; n < BEATS_PER_PHASE; n++)
                send_request(random_request());
            drain();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.pending() != 0)
            sb.report($sformatf("%0d result beats never returned", sb.pending()));
        if (sb.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
src/rtu_pkg.sv
src/rtu_intf.sv
src/rtu_decide.sv
src/riscv_trap_entry_unit_top.sv
dv/tb_riscv_trap_entry_unit_top.sv
